@@ sv/crc8fr_pkg.sv @@
// ----------------------------------------------------------------------------
// crc8fr_pkg
// Shared types, codes and the CRC-8/MAXIM byte update for the frame receiver.
// ----------------------------------------------------------------------------
package crc8fr_pkg;

  localparam logic [7:0] FrameHeader = 8'h55;
  localparam logic [7:0] MinFrame    = 8'd5;
  localparam logic [6:0] CountCeil   = 7'd127;
  localparam logic [7:0] CrcPoly     = 8'h8C;

  localparam int unsigned OutDataW = 48;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_SHORT     = 3'd1,
    ST_LONG      = 3'd2,
    ST_BAD_HDR   = 3'd3,
    ST_CRC_ERR   = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    ACT_NONE    = 2'd0,
    ACT_BATTERY = 2'd1,
    ACT_MESSAGE = 2'd2,
    ACT_IN_CASE = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    REG_BATTERY_CMD = 2'd0,
    REG_MESSAGE_CMD = 2'd1,
    REG_IN_CASE_CMD = 2'd2
  } reg_idx_e;

  typedef struct packed {
    status_e     frame_status;
    logic        seq_mismatch;
    logic [7:0]  command_id;
    logic [7:0]  payload_length;
    action_e     action;
    logic [15:0] message_value;
    logic [7:0]  peer_battery;
    logic        peer_in_case;
  } result_t;

  function automatic logic [7:0] crc_update(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CrcPoly) : (c >> 1);
    end
    return c;
  endfunction

endpackage

@@ sv/crc8fr_in_stage.sv @@
// ----------------------------------------------------------------------------
// crc8fr_in_stage
// Input register for incoming frame bytes, with stream handshake.
// ----------------------------------------------------------------------------
module crc8fr_in_stage (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       valid_i,
  output logic       ready_o,
  input  logic [7:0] data_i,
  input  logic       last_i,
  output logic       valid_o,
  input  logic       take_i,
  output logic [7:0] data_o,
  output logic       last_o
);

  logic       valid_q, valid_d;
  logic [7:0] data_q;
  logic       last_q;

  assign ready_o = !valid_q || take_i;
  assign valid_d = (valid_i && ready_o) || (valid_q && !take_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      data_q <= data_i;
      last_q <= last_i;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;
  assign last_o  = last_q;

endmodule

@@ sv/crc8fr_core.sv @@
// ----------------------------------------------------------------------------
// crc8fr_core
// Frame state, running CRC, header capture, status check and dispatch.
// ----------------------------------------------------------------------------
module crc8fr_core #(
  parameter int unsigned MAX_FRAME = 64
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                fire_i,
  input  logic [7:0]          data_i,
  input  logic                last_i,
  input  logic                cfg_we_i,
  input  logic [1:0]          cfg_index_i,
  input  logic [7:0]          cfg_data_i,
  output logic                res_valid_o,
  output crc8fr_pkg::result_t res_o
);

  localparam logic [7:0] MaxFrameC = 8'(MAX_FRAME);

  logic [7:0] batt_code_q, msg_code_q, case_code_q;
  logic [6:0] count_q, count_d;
  logic [7:0] crc_q, crc_d;
  logic [7:0] hdr_q, seq_q, cmd_q, size_q, pay0_q, pay1_q;
  logic [7:0] exp_seq_q, exp_seq_d;
  logic [7:0] batt_q, batt_d;
  logic       in_case_q, in_case_d;

  logic [7:0] hdr, seq, cmd, size, pay0, pay1;
  logic [6:0] n;
  crc8fr_pkg::result_t res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      batt_code_q <= 8'd0;
      msg_code_q  <= 8'd1;
      case_code_q <= 8'd2;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        crc8fr_pkg::REG_BATTERY_CMD: batt_code_q <= cfg_data_i;
        crc8fr_pkg::REG_MESSAGE_CMD: msg_code_q  <= cfg_data_i;
        crc8fr_pkg::REG_IN_CASE_CMD: case_code_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign hdr  = (count_q == 7'd0) ? data_i : hdr_q;
  assign seq  = (count_q == 7'd1) ? data_i : seq_q;
  assign cmd  = (count_q == 7'd2) ? data_i : cmd_q;
  assign size = (count_q == 7'd3) ? data_i : size_q;
  assign pay0 = (count_q == 7'd4) ? data_i : pay0_q;
  assign pay1 = (count_q == 7'd5) ? data_i : pay1_q;
  assign n    = (count_q == crc8fr_pkg::CountCeil) ? count_q : count_q + 7'd1;

  always_comb begin
    res       = '0;
    exp_seq_d = exp_seq_q;
    batt_d    = batt_q;
    in_case_d = in_case_q;
    if ({1'b0, n} < crc8fr_pkg::MinFrame) begin
      res.frame_status = crc8fr_pkg::ST_SHORT;
    end else if ({1'b0, n} > MaxFrameC) begin
      res.frame_status = crc8fr_pkg::ST_LONG;
    end else if (hdr != crc8fr_pkg::FrameHeader) begin
      res.frame_status = crc8fr_pkg::ST_BAD_HDR;
    end else if (crc_q != data_i) begin
      res.frame_status = crc8fr_pkg::ST_CRC_ERR;
    end else begin
      res.frame_status = crc8fr_pkg::ST_OK;
    end
    if (res.frame_status != crc8fr_pkg::ST_SHORT) begin
      res.command_id     = cmd;
      res.payload_length = size;
    end
    if (res.frame_status == crc8fr_pkg::ST_OK) begin
      res.seq_mismatch = (seq != exp_seq_q);
      exp_seq_d        = seq + 8'd1;
      if (cmd == batt_code_q) begin
        if (size == 8'd1) begin
          batt_d     = pay0;
          res.action = crc8fr_pkg::ACT_BATTERY;
        end
      end else if (cmd == msg_code_q) begin
        if (size == 8'd2) begin
          res.message_value = {pay0, pay1};
          res.action        = crc8fr_pkg::ACT_MESSAGE;
        end
      end else if (cmd == case_code_q) begin
        if (size == 8'd1) begin
          in_case_d  = (pay0 != 8'd0);
          res.action = crc8fr_pkg::ACT_IN_CASE;
        end
      end
    end
    res.peer_battery = batt_d;
    res.peer_in_case = in_case_d;
  end

  assign count_d = last_i ? 7'd0 : n;
  assign crc_d   = last_i ? 8'd0 : crc8fr_pkg::crc_update(crc_q, data_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q   <= 7'd0;
      crc_q     <= 8'd0;
      exp_seq_q <= 8'd0;
      batt_q    <= 8'd0;
      in_case_q <= 1'b0;
    end else if (fire_i) begin
      count_q <= count_d;
      crc_q   <= crc_d;
      if (last_i) begin
        exp_seq_q <= exp_seq_d;
        batt_q    <= batt_d;
        in_case_q <= in_case_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire_i) begin
      hdr_q  <= hdr;
      seq_q  <= seq;
      cmd_q  <= cmd;
      size_q <= size;
      pay0_q <= pay0;
      pay1_q <= pay1;
    end
  end

  assign res_valid_o = fire_i && last_i;
  assign res_o       = res;

endmodule

@@ sv/crc8fr_out_stage.sv @@
// ----------------------------------------------------------------------------
// crc8fr_out_stage
// Result register that packs the frame report onto the output stream.
// ----------------------------------------------------------------------------
module crc8fr_out_stage (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  load_i,
  input  crc8fr_pkg::result_t                   res_i,
  output logic                                  free_o,
  output logic                                  valid_o,
  input  logic                                  ready_i,
  output logic [crc8fr_pkg::OutDataW-1:0]       data_o
);

  logic                valid_q, valid_d;
  crc8fr_pkg::result_t res_q;

  assign free_o  = !valid_q || ready_i;
  assign valid_d = load_i || (valid_q && !ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = {1'b0, res_q.peer_in_case, res_q.peer_battery, res_q.message_value,
                    res_q.action, res_q.payload_length, res_q.command_id,
                    res_q.seq_mismatch, res_q.frame_status};

endmodule

@@ sv/crc8_frame_receiver.sv @@
// ----------------------------------------------------------------------------
// crc8_frame_receiver
// Receives framed bytes, checks length, header and CRC-8/MAXIM, tracks the
// sequence number and dispatches battery, message and in-case commands.
// ----------------------------------------------------------------------------
//  Channel   Direction  Carries
//  s_axis    in         one frame byte per request, tlast on the CRC byte
//  m_axis    out        one frame report per request, after each last byte
//  cfg       in         command code writes, indexes 0 to 2
//
// A byte is taken into the input register, then processed by the core, so
// one byte is accepted per cycle; a stalled output holds only a last byte,
// other bytes keep flowing. The core's report is loaded into the output
// register as the last byte leaves the input register. Reset clears the
// frame counter, CRC, expected sequence number and peer state.
// ----------------------------------------------------------------------------
module crc8_frame_receiver #(
  parameter int unsigned MAX_FRAME = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [2:0] frame_status, [3] seq_mismatch, [11:4] command_id,
  // [19:12] payload_length, [21:20] action, [37:22] message_value,
  // [45:38] peer_battery, [46] peer_in_case, [47] zero
  output logic [47:0] m_axis_tdata,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [7:0]  cfg_data_i
);

  logic                in_valid, in_last, take, res_valid, out_free;
  logic [7:0]          in_data;
  crc8fr_pkg::result_t res;

  assign take = in_valid && (!in_last || out_free);

  crc8fr_in_stage u_in (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s_axis_tvalid),
    .ready_o (s_axis_tready),
    .data_i  (s_axis_tdata),
    .last_i  (s_axis_tlast),
    .valid_o (in_valid),
    .take_i  (take),
    .data_o  (in_data),
    .last_o  (in_last)
  );

  crc8fr_core #(
    .MAX_FRAME (MAX_FRAME)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fire_i      (take),
    .data_i      (in_data),
    .last_i      (in_last),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  crc8fr_out_stage u_out (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (res_valid),
    .res_i   (res),
    .free_o  (out_free),
    .valid_o (m_axis_tvalid),
    .ready_i (m_axis_tready),
    .data_o  (m_axis_tdata)
  );

endmodule

@@ tb/sv/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the CRC-8 frame receiver. Frames are built with
// their CRC, sequence numbers and command codes, fed one byte per request
// under random bursts and gaps, and every report is checked field by field
// against a behavioural predictor kept in step with the accepted bytes.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned MaxFrame     = 64;
  localparam int unsigned ItemTarget   = 1850;
  localparam int unsigned SettleCycles = 8;
  localparam int unsigned LongHold     = 300;
  localparam int unsigned CycleLimit   = 600000;
  localparam logic [1:0]  RegUnused    = 2'd3;

  logic        clk_i;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata  = 8'h00;
  logic        s_axis_tlast  = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [47:0] m_axis_tdata;
  logic        cfg_we_i      = 1'b0;
  logic [1:0]  cfg_index_i   = crc8fr_pkg::REG_BATTERY_CMD;
  logic [7:0]  cfg_data_i    = 8'h00;

  logic [6:0] frame_len     = '0;
  logic [7:0] frame_crc     = '0;
  logic [7:0] hdr_cap       = '0;
  logic [7:0] seq_cap       = '0;
  logic [7:0] cmd_cap       = '0;
  logic [7:0] size_cap      = '0;
  logic [7:0] pay0_cap      = '0;
  logic [7:0] pay1_cap      = '0;
  logic [7:0] next_seq      = '0;
  logic [7:0] battery_level = '0;
  logic       in_case_flag  = 1'b0;
  logic [7:0] code_battery  = 8'd0;
  logic [7:0] code_message  = 8'd1;
  logic [7:0] code_in_case  = 8'd2;

  crc8fr_pkg::result_t expected_reports[$];
  logic [7:0]  frame_buf[$];
  int unsigned fail_count    = 0;
  int unsigned bytes_sent    = 0;
  int unsigned burst_left    = 0;
  int unsigned cycle_count   = 0;
  int unsigned rx_left       = 0;
  int unsigned rx_mode       = 0;
  logic        long_hold_req = 1'b0;

  crc8_frame_receiver #(
    .MAX_FRAME(MaxFrame)
  ) DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic logic [7:0] crc8_maxim_step(input logic [7:0] crc, input logic [7:0] d);
    logic [7:0] r;
    r = crc ^ d;
    repeat (8) r = r[0] ? ((r >> 1) ^ crc8fr_pkg::CrcPoly) : (r >> 1);
    return r;
  endfunction

  task automatic model_frame_byte(input logic [7:0] d, input logic l);
    int unsigned         n;
    crc8fr_pkg::result_t r;
    case (frame_len)
      7'd0: hdr_cap = d;
      7'd1: seq_cap = d;
      7'd2: cmd_cap = d;
      7'd3: size_cap = d;
      7'd4: pay0_cap = d;
      7'd5: pay1_cap = d;
      default: ;
    endcase
    n = frame_len + 1;
    if (n > crc8fr_pkg::CountCeil) n = crc8fr_pkg::CountCeil;
    if (!l) begin
      frame_crc = crc8_maxim_step(frame_crc, d);
      frame_len = 7'(n);
      return;
    end
    r = '0;
    if (n < crc8fr_pkg::MinFrame) r.frame_status = crc8fr_pkg::ST_SHORT;
    else if (n > MaxFrame) r.frame_status = crc8fr_pkg::ST_LONG;
    else if (hdr_cap != crc8fr_pkg::FrameHeader) r.frame_status = crc8fr_pkg::ST_BAD_HDR;
    else if (frame_crc != d) r.frame_status = crc8fr_pkg::ST_CRC_ERR;
    else r.frame_status = crc8fr_pkg::ST_OK;
    if (r.frame_status != crc8fr_pkg::ST_SHORT) begin
      r.command_id     = cmd_cap;
      r.payload_length = size_cap;
    end
    if (r.frame_status == crc8fr_pkg::ST_OK) begin
      if (seq_cap != next_seq) begin
        r.seq_mismatch = 1'b1;
        next_seq       = seq_cap;
      end
      next_seq = next_seq + 8'd1;
      if (cmd_cap == code_battery) begin
        if (size_cap == 8'd1) begin
          battery_level = pay0_cap;
          r.action      = crc8fr_pkg::ACT_BATTERY;
        end
      end else if (cmd_cap == code_message) begin
        if (size_cap == 8'd2) begin
          r.message_value = {pay0_cap, pay1_cap};
          r.action        = crc8fr_pkg::ACT_MESSAGE;
        end
      end else if (cmd_cap == code_in_case) begin
        if (size_cap == 8'd1) begin
          in_case_flag = (pay0_cap != 8'd0);
          r.action     = crc8fr_pkg::ACT_IN_CASE;
        end
      end
    end
    r.peer_battery = battery_level;
    r.peer_in_case = in_case_flag;
    frame_len = '0;
    frame_crc = '0;
    expected_reports.push_back(r);
  endtask

  task automatic compare_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, actual %0h", name, want, got);
      fail_count++;
    end
  endtask

  task automatic check_report(input logic [47:0] t);
    crc8fr_pkg::result_t want;
    if (expected_reports.size() == 0) begin
      $error("report %h arrived with no frame outstanding", t);
      fail_count++;
      return;
    end
    want = expected_reports.pop_front();
    compare_field("frame_status", 16'(want.frame_status), 16'(t[2:0]));
    compare_field("seq_mismatch", 16'(want.seq_mismatch), 16'(t[3]));
    compare_field("command_id", 16'(want.command_id), 16'(t[11:4]));
    compare_field("payload_length", 16'(want.payload_length), 16'(t[19:12]));
    compare_field("action", 16'(want.action), 16'(t[21:20]));
    compare_field("message_value", want.message_value, t[37:22]);
    compare_field("peer_battery", 16'(want.peer_battery), 16'(t[45:38]));
    compare_field("peer_in_case", 16'(want.peer_in_case), 16'(t[46]));
  endtask

  initial begin
    forever begin
      @(posedge clk_i);
      if (rst_ni && m_axis_tvalid && m_axis_tready) check_report(m_axis_tdata);
    end
  end

  initial begin
    forever begin
      @(posedge clk_i);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        m_axis_tready <= 1'b0;
        repeat (LongHold) @(posedge clk_i);
      end else begin
        if (rx_left == 0) begin
          rx_mode = $urandom_range(0, 2);
          rx_left = $urandom_range(4, 60);
        end
        rx_left--;
        case (rx_mode)
          0: m_axis_tready <= 1'b1;
          1: m_axis_tready <= 1'($urandom_range(0, 1));
          default: m_axis_tready <= (rx_left % 5) != 0;
        endcase
      end
    end
  end

  initial begin
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("Some tests failed");
    $finish;
  end

  task automatic send_byte(input logic [7:0] d, input logic l);
    if (burst_left == 0) begin
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
      burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
                                                : $urandom_range(1, 40);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= d;
    s_axis_tlast  <= l;
    do @(posedge clk_i); while (!s_axis_tready);
    model_frame_byte(d, l);
    bytes_sent++;
    burst_left--;
    if (burst_left == 0) s_axis_tvalid <= 1'b0;
  endtask

  task automatic wait_idle();
    if (burst_left != 0) s_axis_tvalid <= 1'b0;
    burst_left = 0;
    while (expected_reports.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_cmd_code(input logic [1:0] idx, input logic [7:0] value);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      crc8fr_pkg::REG_BATTERY_CMD: code_battery = value;
      crc8fr_pkg::REG_MESSAGE_CMD: code_message = value;
      crc8fr_pkg::REG_IN_CASE_CMD: code_in_case = value;
      default: ;
    endcase
  endtask

  task automatic transmit_frame();
    int i;
    for (i = 0; i < frame_buf.size(); i++) send_byte(frame_buf[i], i == frame_buf.size() - 1);
    frame_buf.delete();
  endtask

  task automatic open_frame(input logic [7:0] seq, input logic [7:0] cmd,
                            input logic [7:0] size);
    frame_buf.delete();
    frame_buf.push_back(crc8fr_pkg::FrameHeader);
    frame_buf.push_back(seq);
    frame_buf.push_back(cmd);
    frame_buf.push_back(size);
  endtask

  task automatic push_payload(input int count);
    repeat (count) frame_buf.push_back(8'($urandom_range(0, 255)));
  endtask

  task automatic close_frame(input bit crc_good);
    logic [7:0] crc;
    crc = '0;
    foreach (frame_buf[i]) crc = crc8_maxim_step(crc, frame_buf[i]);
    if (!crc_good) crc = crc ^ 8'($urandom_range(1, 255));
    frame_buf.push_back(crc);
    transmit_frame();
  endtask

  task automatic random_frame();
    int         kind;
    int         pick;
    int         count;
    logic [7:0] seq;
    logic [7:0] cmd;
    logic [7:0] size;
    kind = $urandom_range(0, 99);
    frame_buf.delete();
    if (kind >= 85 && kind < 91) begin
      push_payload($urandom_range(1, 4));
      if ($urandom_range(0, 1) == 1) frame_buf[0] = crc8fr_pkg::FrameHeader;
      transmit_frame();
      return;
    end
    if (kind >= 95) begin
      push_payload($urandom_range(1, 20));
      transmit_frame();
      return;
    end
    pick = $urandom_range(0, 9);
    seq  = ($urandom_range(0, 6) == 0) ? 8'($urandom_range(0, 255)) : next_seq;
    size = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                       : 8'($urandom_range(0, 6));
    if (pick < 3) cmd = code_battery;
    else if (pick < 6) cmd = code_message;
    else if (pick < 8) cmd = code_in_case;
    else cmd = 8'($urandom_range(0, 255));
    if (pick < 8 && $urandom_range(0, 7) != 0) size = (pick >= 3 && pick < 6) ? 8'd2 : 8'd1;
    count = size;
    if (kind >= 91) count = $urandom_range(MaxFrame - 4, 140);
    else if (size > MaxFrame - 5 || $urandom_range(0, 9) == 0) count = $urandom_range(0, 8);
    open_frame(seq, cmd, size);
    push_payload(count);
    if (kind >= 78 && kind < 85) begin
      frame_buf[0] = crc8fr_pkg::FrameHeader ^ 8'($urandom_range(1, 255));
    end
    close_frame(!(kind >= 70 && kind < 78));
  endtask

  task automatic test_default_commands();
    open_frame(next_seq, 8'd1, 8'd2);
    frame_buf.push_back(8'hAB);
    frame_buf.push_back(8'hCD);
    close_frame(1'b1);
    open_frame(next_seq, 8'd0, 8'd1);
    frame_buf.push_back(8'hFF);
    close_frame(1'b1);
    open_frame(next_seq, 8'd2, 8'd1);
    frame_buf.push_back(8'h80);
    close_frame(1'b1);
    open_frame(next_seq, 8'd2, 8'd1);
    frame_buf.push_back(8'h00);
    close_frame(1'b1);
    open_frame(next_seq, 8'd0, 8'd1);
    frame_buf.push_back(8'h00);
    close_frame(1'b1);
    open_frame(8'hFF, 8'd1, 8'd2);
    frame_buf.push_back(8'h00);
    frame_buf.push_back(8'h00);
    close_frame(1'b1);
    open_frame(8'h00, 8'hFF, 8'd0);
    close_frame(1'b1);
    open_frame(next_seq, 8'd0, 8'd2);
    push_payload(2);
    close_frame(1'b1);
    open_frame(next_seq, 8'd1, 8'd1);
    push_payload(1);
    close_frame(1'b1);
    // The size byte claims two payload bytes, so the CRC lands in the first.
    open_frame(next_seq, 8'd1, 8'd2);
    close_frame(1'b1);
    open_frame(next_seq, 8'd0, 8'd9);
    push_payload(1);
    close_frame(1'b1);
  endtask

  task automatic test_frame_errors();
    push_payload(1);
    transmit_frame();
    open_frame(next_seq, 8'd0, 8'd1);
    transmit_frame();
    open_frame(next_seq, 8'd1, 8'd0);
    close_frame(1'b1);
    open_frame(next_seq, 8'd1, 8'd2);
    push_payload(2);
    frame_buf[0] = 8'h54;
    close_frame(1'b1);
    open_frame(next_seq, 8'd1, 8'd2);
    push_payload(2);
    frame_buf[0] = 8'hD5;
    close_frame(1'b0);
    open_frame(next_seq, 8'd0, 8'd1);
    push_payload(1);
    close_frame(1'b0);
  endtask

  task automatic test_long_frames();
    open_frame(next_seq, 8'd0, 8'd1);
    push_payload(MaxFrame - 5);
    close_frame(1'b1);
    open_frame(next_seq, 8'd0, 8'd1);
    push_payload(MaxFrame - 4);
    close_frame(1'b1);
    open_frame(next_seq, 8'd2, 8'd1);
    push_payload(125);
    frame_buf[0] = 8'h00;
    close_frame(1'b0);
  endtask

  task automatic test_command_codes();
    wait_idle();
    write_cmd_code(crc8fr_pkg::REG_BATTERY_CMD, 8'h00);
    write_cmd_code(crc8fr_pkg::REG_MESSAGE_CMD, 8'h00);
    write_cmd_code(crc8fr_pkg::REG_IN_CASE_CMD, 8'h00);
    open_frame(next_seq, 8'h00, 8'd1);
    push_payload(1);
    close_frame(1'b1);
    open_frame(next_seq, 8'h00, 8'd2);
    push_payload(2);
    close_frame(1'b1);
    wait_idle();
    write_cmd_code(crc8fr_pkg::REG_BATTERY_CMD, 8'hFF);
    write_cmd_code(crc8fr_pkg::REG_MESSAGE_CMD, 8'h80);
    write_cmd_code(crc8fr_pkg::REG_IN_CASE_CMD, 8'h80);
    open_frame(next_seq, 8'h80, 8'd1);
    push_payload(1);
    close_frame(1'b1);
    open_frame(next_seq, 8'h80, 8'd2);
    push_payload(2);
    close_frame(1'b1);
    open_frame(next_seq, 8'hFF, 8'd1);
    push_payload(1);
    close_frame(1'b1);
    wait_idle();
    write_cmd_code(crc8fr_pkg::REG_IN_CASE_CMD, 8'h7F);
    write_cmd_code(RegUnused, 8'hFF);
    open_frame(next_seq, 8'h7F, 8'd1);
    frame_buf.push_back(8'h01);
    close_frame(1'b1);
    open_frame(next_seq, 8'hFF, 8'd1);
    push_payload(1);
    close_frame(1'b1);
  endtask

  task automatic test_backpressure();
    wait_idle();
    long_hold_req = 1'b1;
    repeat (10) begin
      open_frame(next_seq, ($urandom_range(0, 1) == 1) ? code_battery : code_message,
                 8'($urandom_range(0, 2)));
      push_payload($urandom_range(0, 2));
      close_frame(1'b1);
    end
    wait_idle();
  endtask

  task automatic test_random_traffic();
    int unsigned start;
    int unsigned span;
    int unsigned ph;
    start = bytes_sent;
    span  = (ItemTarget > start) ? ItemTarget - start : 0;
    for (ph = 0; ph < 6; ph++) begin
      wait_idle();
      if (ph == 0) begin
        write_cmd_code(crc8fr_pkg::REG_BATTERY_CMD, 8'h00);
        write_cmd_code(crc8fr_pkg::REG_MESSAGE_CMD, 8'hFF);
        write_cmd_code(crc8fr_pkg::REG_IN_CASE_CMD, 8'hFF);
      end else if (ph == 5) begin
        write_cmd_code(crc8fr_pkg::REG_BATTERY_CMD, 8'd0);
        write_cmd_code(crc8fr_pkg::REG_MESSAGE_CMD, 8'd1);
        write_cmd_code(crc8fr_pkg::REG_IN_CASE_CMD, 8'd2);
      end else begin
        write_cmd_code(crc8fr_pkg::REG_BATTERY_CMD, 8'($urandom_range(0, 255)));
        write_cmd_code(crc8fr_pkg::REG_MESSAGE_CMD, 8'($urandom_range(0, 255)));
        write_cmd_code(crc8fr_pkg::REG_IN_CASE_CMD,
                       ($urandom_range(0, 2) == 0) ? code_message : 8'($urandom_range(0, 255)));
      end
      while (bytes_sent - start < span * (ph + 1) / 6) random_frame();
    end
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_default_commands();
    test_frame_errors();
    test_long_frames();
    test_command_codes();
    test_backpressure();
    test_random_traffic();
    wait_idle();
    if (expected_reports.size() != 0) begin
      $error("%0d reports never arrived", expected_reports.size());
      fail_count++;
    end
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

@@ sim.f @@
sv/crc8fr_pkg.sv
sv/crc8fr_in_stage.sv
sv/crc8fr_core.sv
sv/crc8fr_out_stage.sv
sv/crc8_frame_receiver.sv
tb/sv/tb.sv
